// ===== hw/rtl/ctfs_pkg.sv =====
package ctfs_pkg;

	// payload widths fixed by the channel definitions
	localparam int unsigned ID_W   = 64;
	localparam int unsigned OBS_W  = 64;
	localparam int unsigned CNT32_W = 32;
	localparam int unsigned USED_W = 3;

	// default target table depth
	localparam int unsigned DEF_MAX_ENTRIES = 4;

	// APB register file: one 32-bit register at byte 0
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic REG_MIN_HITS = 1'b0;   // word index bit paddr[2]

	// request commands
	localparam logic CMD_OBSERVE = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	// call site mode
	typedef enum logic [1:0] {
		MODE_UNINIT = 2'd0,
		MODE_MONO   = 2'd1,
		MODE_POLY   = 2'd2,
		MODE_MEGA   = 2'd3
	} mode_t;

	// table update for one request
	typedef struct packed {
		logic            clear;
		logic            hit;
		logic            app;
		logic [ID_W-1:0] id;
	} table_op_t;

	function automatic logic [CNT32_W-1:0] sat_inc32(input logic [CNT32_W-1:0] v);
		sat_inc32 = (&v) ? v : v + CNT32_W'(1);
	endfunction

	function automatic logic [OBS_W-1:0] sat_inc64(input logic [OBS_W-1:0] v);
		sat_inc64 = (&v) ? v : v + OBS_W'(1);
	endfunction

endpackage

// ===== hw/rtl/ctfs_if.sv =====
// request channel: command and target identity
interface ctfs_req_if;
	import ctfs_pkg::*;

	logic            valid;
	logic            ready;
	logic            command;
	logic [ID_W-1:0] target_id;

	modport source (output valid, command, target_id, input ready);
	modport sink   (input valid, command, target_id, output ready);
endinterface

// result channel: slot state after each request
interface ctfs_res_if;
	import ctfs_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic               matched;
	logic               mono_ready;
	logic [ID_W-1:0]    mono_target;
	logic [OBS_W-1:0]   observations;
	logic [CNT32_W-1:0] miss_total;
	logic [CNT32_W-1:0] generation;
	logic [USED_W-1:0]  entries_used;

	modport source (output valid, mode, matched, mono_ready, mono_target, observations,
		miss_total, generation, entries_used, input ready);
	modport sink   (input valid, mode, matched, mono_ready, mono_target, observations,
		miss_total, generation, entries_used, output ready);
endinterface

// ===== hw/rtl/ctfs_table.sv =====
module ctfs_table #(
	parameter int unsigned MAX_ENTRIES = ctfs_pkg::DEF_MAX_ENTRIES,
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ctfs_pkg::ID_W-1:0]   lookup_id,
	input  ctfs_pkg::table_op_t         op,
	output logic [MAX_ENTRIES-1:0]      match,
	output logic                        full,
	output logic [CNT_W-1:0]            count,
	output logic [CNT_W-1:0]            count_nxt,
	output logic [ctfs_pkg::ID_W-1:0]   id0_nxt,
	output logic [ctfs_pkg::CNT32_W-1:0] hits0_nxt
);
	import ctfs_pkg::*;

	logic [CNT_W-1:0]   count_q;
	logic [ID_W-1:0]    ids_q  [MAX_ENTRIES];
	logic [CNT32_W-1:0] hits_q [MAX_ENTRIES];
	logic               found;

	// first filled entry that holds the identity
	always_comb begin
		found = 1'b0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = 1'b0;
			if (!found && (CNT_W'(i) < count_q) && (ids_q[i] == lookup_id)) begin
				match[i] = 1'b1;
				found    = 1'b1;
			end
		end
	end

	assign count = count_q;
	assign full  = (count_q == CNT_W'(MAX_ENTRIES));

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.clear) begin
			count_q <= '0;
		end else if (op.app) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// entry contents, valid only below the fill count
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (op.app && (count_q == CNT_W'(i))) begin
				ids_q[i]  <= op.id;
				hits_q[i] <= CNT32_W'(1);
			end else if (op.hit && match[i]) begin
				hits_q[i] <= sat_inc32(hits_q[i]);
			end
		end
	end

	// view of the table after this request
	always_comb begin
		count_nxt = op.clear ? '0 : (op.app ? count_q + CNT_W'(1) : count_q);
		if (op.app && (count_q == '0)) begin
			id0_nxt   = op.id;
			hits0_nxt = CNT32_W'(1);
		end else if (op.hit && match[0]) begin
			id0_nxt   = ids_q[0];
			hits0_nxt = sat_inc32(hits_q[0]);
		end else begin
			id0_nxt   = ids_q[0];
			hits0_nxt = hits_q[0];
		end
	end

endmodule

// ===== hw/rtl/call_target_feedback_slot_top.sv =====
// Call target feedback slot: profiles the targets seen at one call site.
// Requests arrive on obs (valid/ready): command 0 observes target_id,
// command 1 clears the slot. Each request gives exactly one result on res
// (valid/ready) with the mode, match flag, monomorphic readiness and target,
// and the observation, miss and generation counters after that request.
// min_hits is written over APB at byte 0; prdata reads it back.
// Throughput: one request per cycle while res is not stalled. A request
// is taken into the input register, matched against every table entry
// in parallel, and the slot is updated as the request moves on into the
// result register, which drives res.valid.
// When res is stalled the result register holds and the input register
// keeps its request; obs.ready drops once both are occupied and res.ready
// is low.
// Reset empties both registers, clears mode, fill count and counters, and
// sets min_hits to 0. Table contents are not cleared; entries above the
// fill count are never matched.
module call_target_feedback_slot_top #(
	parameter int unsigned MAX_ENTRIES = ctfs_pkg::DEF_MAX_ENTRIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ctfs_req_if.sink                          obs,
	ctfs_res_if.source                        res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ctfs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ctfs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ctfs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import ctfs_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

	// configuration
	logic [CNT32_W-1:0] min_hits_q;

	// input register
	logic            valid_s1;
	logic            cmd_s1;
	logic [ID_W-1:0] id_s1;

	// slot state
	mode_t              mode_q;
	logic [OBS_W-1:0]   obs_cnt_q;
	logic [CNT32_W-1:0] miss_cnt_q;
	logic [CNT32_W-1:0] gen_cnt_q;

	// result register
	logic               res_valid_q;
	logic [1:0]         mode_s2;
	logic               matched_s2;
	logic               ready_s2;
	logic [ID_W-1:0]    target_s2;
	logic [OBS_W-1:0]   obs_s2;
	logic [CNT32_W-1:0] miss_s2;
	logic [CNT32_W-1:0] gen_s2;
	logic [USED_W-1:0]  used_s2;

	// step logic
	logic                 adv;
	logic                 fire;
	logic                 is_clear;
	logic                 id_zero;
	logic                 hit;
	logic                 miss;
	logic                 grow;
	table_op_t            op;
	logic [MAX_ENTRIES-1:0] match;
	logic                 full;
	logic [CNT_W-1:0]     count;
	logic [CNT_W-1:0]     count_nxt;
	logic [ID_W-1:0]      id0_nxt;
	logic [CNT32_W-1:0]   hits0_nxt;
	mode_t                mode_nxt;
	logic [OBS_W-1:0]     obs_nxt;
	logic [CNT32_W-1:0]   miss_nxt;
	logic [CNT32_W-1:0]   gen_nxt;
	logic                 mono_rdy;
	logic [CNT_W+2:0]     used_ext;

	// APB register access
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MIN_HITS) ? min_hits_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hits_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_MIN_HITS)) begin
			min_hits_q <= pwdata;
		end
	end

	// handshake: the input register moves on when the result register is free
	assign adv       = !res_valid_q || res.ready;
	assign obs.ready = !valid_s1 || adv;
	assign fire      = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (obs.valid && obs.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (obs.valid && obs.ready) begin
			cmd_s1 <= obs.command;
			id_s1  <= obs.target_id;
		end
	end

	// classify the request
	assign is_clear = (cmd_s1 == CMD_CLEAR);
	assign id_zero  = (id_s1 == '0);
	assign hit      = !is_clear && !id_zero && (|match);
	assign miss     = !is_clear && !hit;
	assign grow     = miss && !id_zero && (mode_q != MODE_MEGA);

	always_comb begin
		op.clear = fire && is_clear;
		op.hit   = fire && hit;
		op.app   = fire && grow && !full;
		op.id    = id_s1;
	end

	ctfs_table #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.lookup_id (id_s1),
		.op        (op),
		.match     (match),
		.full      (full),
		.count     (count),
		.count_nxt (count_nxt),
		.id0_nxt   (id0_nxt),
		.hits0_nxt (hits0_nxt)
	);

	// next mode and counters
	always_comb begin
		if (is_clear) begin
			mode_nxt = MODE_UNINIT;
		end else if (grow && !full) begin
			mode_nxt = (count == '0) ? MODE_MONO : MODE_POLY;
		end else if (grow) begin
			mode_nxt = MODE_MEGA;
		end else begin
			mode_nxt = mode_q;
		end
		obs_nxt  = is_clear ? '0 : sat_inc64(obs_cnt_q);
		miss_nxt = is_clear ? '0 : (miss ? sat_inc32(miss_cnt_q) : miss_cnt_q);
		if (is_clear) begin
			gen_nxt = '0;
		end else if (mode_nxt != mode_q) begin
			gen_nxt = sat_inc32(gen_cnt_q);
		end else begin
			gen_nxt = gen_cnt_q;
		end
		mono_rdy = (mode_nxt == MODE_MONO) && (count_nxt == CNT_W'(1)) &&
			(hits0_nxt >= min_hits_q);
		used_ext = {3'b000, count_nxt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_UNINIT;
			obs_cnt_q  <= '0;
			miss_cnt_q <= '0;
			gen_cnt_q  <= '0;
		end else if (fire) begin
			mode_q     <= mode_nxt;
			obs_cnt_q  <= obs_nxt;
			miss_cnt_q <= miss_nxt;
			gen_cnt_q  <= gen_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mode_s2    <= mode_nxt;
			matched_s2 <= hit;
			ready_s2   <= mono_rdy;
			target_s2  <= mono_rdy ? id0_nxt : '0;
			obs_s2     <= obs_nxt;
			miss_s2    <= miss_nxt;
			gen_s2     <= gen_nxt;
			used_s2    <= used_ext[USED_W-1:0];
		end
	end

	assign res.valid        = res_valid_q;
	assign res.mode         = mode_s2;
	assign res.matched      = matched_s2;
	assign res.mono_ready   = ready_s2;
	assign res.mono_target  = target_s2;
	assign res.observations = obs_s2;
	assign res.miss_total   = miss_s2;
	assign res.generation   = gen_s2;
	assign res.entries_used = used_s2;

	// a ready monomorphic slot has exactly one entry
	a_mono_ready_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.mono_ready |-> (res.mode == MODE_MONO) && (res.entries_used == 3'd1))
		else $error("mono_ready outside a single-entry monomorphic slot");

	// target shown only when ready
	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.mono_ready |-> (res.mono_target == '0))
		else $error("mono_target nonzero without mono_ready");

	// a hit implies at least one observation counted
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.matched |-> (res.observations != '0))
		else $error("hit reported with zero observations");

	// a clear shows an empty slot on the next result
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_clear |=> res.valid && (res.observations == '0) &&
			(res.generation == '0) && (res.entries_used == '0) && !res.matched)
		else $error("clear did not restore reset contents");

endmodule
